>>> design/ed_pkg.sv
// Shared constants and types for the edit distance engine.
package ed_pkg;

    localparam int MAX_LEN  = 64;
    localparam int COST_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W    = 16;
    localparam int OP_W     = 2;
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [SYM_W-1:0]  sym;
        logic [COST_W-1:0] left;
        logic [COST_W-1:0] diag;
    } ed_wave_t;

    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  sym;
        logic [COST_W-1:0] cost;
    } ed_load_t;

endpackage

>>> design/ed_cell.sv
// One row cell: holds a reference symbol and its cost entry, updates on each wavefront.
module ed_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  ed_pkg::ed_load_t load,
    input  ed_pkg::ed_wave_t wave_in,
    output ed_pkg::ed_wave_t wave_out,
    output logic [ed_pkg::COST_W-1:0] cost
);
    import ed_pkg::*;

    logic [SYM_W-1:0]  ref_reg;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    logic [COST_W-1:0] min_ab;
    logic [COST_W-1:0] min_abc;
    logic [SYM_W-1:0]  sym_reg;
    logic [COST_W-1:0] left_reg;
    logic [COST_W-1:0] diag_reg;
    logic              valid_reg;

    always_comb
    begin
        min_ab  = (wave_in.left < cost_reg) ? wave_in.left : cost_reg;
        min_abc = (min_ab < wave_in.diag) ? min_ab : wave_in.diag;
        if (ref_reg == wave_in.sym)
        begin
            cost_next = wave_in.diag;
        end
        else
        begin
            cost_next = min_abc + COST_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.en)
        begin
            ref_reg  <= load.sym;
            cost_reg <= load.cost;
        end
        else if (wave_in.valid)
        begin
            cost_reg <= cost_next;
        end
        sym_reg  <= wave_in.sym;
        left_reg <= cost_next;
        diag_reg <= cost_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= wave_in.valid;
        end
    end

    always_comb
    begin
        wave_out.valid = valid_reg;
        wave_out.sym   = sym_reg;
        wave_out.left  = left_reg;
        wave_out.diag  = diag_reg;
    end

    assign cost = cost_reg;

endmodule

>>> design/edit_distance_engine.sv
// Top level: Levenshtein edit distance over a systolic row of cells.
// Load and search requests never raise busy and may follow back to back; a search
// symbol travels down the row one cell per cycle, so a finish request holds busy while
// the last wavefront drains, then shows distance and overflow on the cycle done is high.
// The result must be taken in that cycle; it is not held.
module edit_distance_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ed_pkg::OP_W-1:0]   op,
    input  logic [ed_pkg::SYM_W-1:0]  symbol,
    output logic                      done,
    output logic [ed_pkg::DIST_W-1:0] distance,
    output logic                      overflow
);
    import ed_pkg::*;

    typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

    state_t            state_reg;
    logic [COST_W-1:0] drain_reg;
    logic [COST_W-1:0] len_reg;
    logic [COST_W-1:0] count_reg;
    logic              ovf_reg;
    logic              done_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              ovf_out_reg;
    logic              wave_v_reg;
    logic [SYM_W-1:0]  wave_sym_reg;
    logic [COST_W-1:0] wave_left_reg;
    logic [COST_W-1:0] wave_diag_reg;

    logic              accept;
    logic              do_load;
    logic              do_search;
    logic [COST_W-1:0] sel_cost;
    logic [DIST_W-1:0] dist_next;

    ed_wave_t          wave [0:MAX_LEN-1];
    logic [COST_W-1:0] costs [0:MAX_LEN];

    assign accept    = start && (state_reg == ST_IDLE);
    assign do_load   = accept && (op == OP_LOAD) && (count_reg == '0)
                       && (len_reg != COST_W'(MAX_LEN));
    assign do_search = accept && (op == OP_SEARCH) && (count_reg != COST_W'(MAX_LEN));

    always_comb
    begin
        wave[0].valid = wave_v_reg;
        wave[0].sym   = wave_sym_reg;
        wave[0].left  = wave_left_reg;
        wave[0].diag  = wave_diag_reg;
    end

    assign costs[0] = count_reg;

    genvar gi;
    generate
        for (gi = 1; gi <= MAX_LEN; gi++)
        begin : g_cell
            ed_load_t ld;
            always_comb
            begin
                ld.en   = do_load && (len_reg == COST_W'(gi - 1));
                ld.sym  = symbol;
                ld.cost = COST_W'(gi);
            end
            if (gi < MAX_LEN)
            begin : g_mid
                ed_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .load     (ld),
                    .wave_in  (wave[gi-1]),
                    .wave_out (wave[gi]),
                    .cost     (costs[gi])
                );
            end
            else
            begin : g_last
                ed_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .load     (ld),
                    .wave_in  (wave[gi-1]),
                    .wave_out (),
                    .cost     (costs[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        sel_cost = costs[len_reg];
        if (32'(sel_cost) > DIST_MAX)
        begin
            dist_next = DIST_W'(DIST_MAX);
        end
        else
        begin
            dist_next = DIST_W'(sel_cost);
        end
    end

    always_ff @(posedge clk)
    begin
        wave_sym_reg  <= symbol;
        wave_left_reg <= count_reg + COST_W'(1);
        wave_diag_reg <= count_reg;
        dist_reg      <= dist_next;
        ovf_out_reg   <= ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            drain_reg  <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            done_reg   <= 1'b0;
            wave_v_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            wave_v_reg <= do_search;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (op)
                            OP_LOAD:
                            begin
                                if (do_load)
                                begin
                                    len_reg <= len_reg + COST_W'(1);
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            OP_SEARCH:
                            begin
                                if (do_search)
                                begin
                                    count_reg <= count_reg + COST_W'(1);
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            OP_FINISH:
                            begin
                                state_reg <= ST_DRAIN;
                                drain_reg <= COST_W'(MAX_LEN - 1);
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DRAIN:
                begin
                    if (drain_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                        len_reg   <= '0;
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                    else
                    begin
                        drain_reg <= drain_reg - COST_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg == ST_DRAIN);
    assign done     = done_reg;
    assign distance = dist_reg;
    assign overflow = ovf_out_reg;

endmodule

>>> design/ed_checker.sv
// Port-level checks on the edit distance engine and their binding to the top level.
module ed_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [ed_pkg::OP_W-1:0]   op,
    input logic                      done
);
    import ed_pkg::*;

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == OP_FINISH) |=> busy)
        else $error("finish request did not raise busy");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (op == OP_FINISH)))
        else $error("busy rose without a finish request");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("drain ended without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && !$past(done))
        else $error("result shown while busy or twice in a row");

endmodule

bind edit_distance_engine ed_checker u_ed_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done)
);

>>> sim/ed_checker.sv
// Checker for the edit distance engine: predicts each finish and compares the result.
module ed_tb_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [ed_pkg::OP_W-1:0]   op,
    input  logic [ed_pkg::SYM_W-1:0]  symbol,
    input  logic                      done,
    input  logic [ed_pkg::DIST_W-1:0] distance,
    input  logic                      overflow,
    output int                        fails,
    output int                        pending,
    output int                        checked
);
    import ed_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } dist_result_t;

    logic [SYM_W-1:0] pat_sym [0:MAX_LEN-1];
    int               dp_row  [0:MAX_LEN];
    int               pat_len;
    int               srch_len;
    logic             trunc_flag;
    dist_result_t     dist_q [$];

    task automatic clear_pair();
        foreach (dp_row[i]) dp_row[i] = 0;
        foreach (pat_sym[i]) pat_sym[i] = '0;
        pat_len    = 0;
        srch_len   = 0;
        trunc_flag = 1'b0;
    endtask

    task automatic apply_request(input logic [OP_W-1:0] o, input logic [SYM_W-1:0] s);
        int           diag;
        int           above;
        int           m;
        int           d;
        dist_result_t res;
        case (o)
            OP_LOAD:
            begin
                if (srch_len != 0 || pat_len >= MAX_LEN)
                begin
                    trunc_flag = 1'b1;
                end
                else
                begin
                    pat_sym[pat_len] = s;
                    pat_len++;
                    dp_row[pat_len] = pat_len;
                end
            end
            OP_SEARCH:
            begin
                if (srch_len >= MAX_LEN)
                begin
                    trunc_flag = 1'b1;
                end
                else
                begin
                    srch_len++;
                    diag      = dp_row[0];
                    dp_row[0] = srch_len;
                    for (int t = 1; t <= pat_len; t++)
                    begin
                        above = dp_row[t];
                        if (pat_sym[t-1] == s)
                        begin
                            dp_row[t] = diag;
                        end
                        else
                        begin
                            m = dp_row[t-1] < above ? dp_row[t-1] : above;
                            m = m < diag ? m : diag;
                            dp_row[t] = m + 1;
                        end
                        diag = above;
                    end
                end
            end
            OP_FINISH:
            begin
                d = dp_row[pat_len];
                if (d > DIST_MAX) d = DIST_MAX;
                res.distance = d[DIST_W-1:0];
                res.overflow = trunc_flag;
                dist_q.push_back(res);
                clear_pair();
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        dist_result_t exp_res;
        if (!rst_n)
        begin
            clear_pair();
            dist_q.delete();
            fails   <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (start && !busy) apply_request(op, symbol);
            if (done)
            begin
                if (dist_q.size() == 0)
                begin
                    if (fails < 10)
                        $display("MISMATCH: result with none expected: distance=%0d overflow=%0b",
                                 distance, overflow);
                    fails <= fails + 1;
                end
                else
                begin
                    exp_res = dist_q.pop_front();
                    checked <= checked + 1;
                    if (distance !== exp_res.distance || overflow !== exp_res.overflow)
                    begin
                        if (fails < 10)
                            $display("MISMATCH: distance exp=%0d act=%0d, overflow exp=%0b act=%0b",
                                     exp_res.distance, distance, exp_res.overflow, overflow);
                        fails <= fails + 1;
                    end
                end
            end
            pending <= dist_q.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// Testbench top for the edit distance engine: clock, reset, request stimulus and verdict.
module tb_top;
    import ed_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RAND_ITEMS = 900;
    localparam int LIMIT      = 500000;

    logic              clk    = 1'b0;
    logic              rst_n  = 1'b0;
    logic              start  = 1'b0;
    logic [OP_W-1:0]   op     = '0;
    logic [SYM_W-1:0]  symbol = '0;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    int fails;
    int pending;
    int checked;
    int cycles = 0;
    int n_load = 0;
    int n_search = 0;
    int n_finish = 0;
    int n_unused = 0;
    bit idle_on = 1'b1;

    always #10 clk = ~clk;

    edit_distance_engine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .symbol   (symbol),
        .done     (done),
        .distance (distance),
        .overflow (overflow)
    );

    ed_tb_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .symbol   (symbol),
        .done     (done),
        .distance (distance),
        .overflow (overflow),
        .fails    (fails),
        .pending  (pending),
        .checked  (checked)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(input logic [OP_W-1:0] o, input logic [SYM_W-1:0] s);
        while (idle_on && $urandom_range(99) < 38)
        begin
            start  <= 1'b0;
            op     <= OP_W'($urandom);
            symbol <= SYM_W'($urandom);
            @(posedge clk);
        end
        start  <= 1'b1;
        op     <= o;
        symbol <= s;
        @(posedge clk);
        while (busy) @(posedge clk);
        case (o)
            OP_LOAD:   n_load++;
            OP_SEARCH: n_search++;
            OP_FINISH: n_finish++;
            default:   n_unused++;
        endcase
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(8);
        if (r < 92) return $urandom_range(9, 30);
        return $urandom_range(60, 70);
    endfunction

    function automatic logic [SYM_W-1:0] pick_sym(bit wide, logic [SYM_W-1:0] base);
        if (wide) return SYM_W'($urandom);
        return base + SYM_W'($urandom_range(3));
    endfunction

    function automatic int real_items();
        return n_load + n_search + n_finish;
    endfunction

    initial
    begin
        int               shape;
        int               rl;
        int               sl;
        int               stop_at;
        bit               wide;
        logic [SYM_W-1:0] base;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pair, then one empty side each way
        send(OP_FINISH, 16'hFFFF);
        send(OP_LOAD, 16'h0000);
        send(OP_FINISH, 16'h0000);
        send(OP_SEARCH, 16'hFFFF);
        send(OP_SEARCH, 16'h1234);
        send(OP_FINISH, 16'h0000);
        // extreme symbols, unused op in between
        send(OP_LOAD, 16'h0000);
        send(OP_LOAD, 16'hFFFF);
        send(OP_UNUSED, 16'h5555);
        send(OP_SEARCH, 16'hFFFF);
        send(OP_SEARCH, 16'h0000);
        send(OP_FINISH, 16'hAAAA);
        // exact match
        send(OP_LOAD, 16'h0061);
        send(OP_LOAD, 16'h0062);
        send(OP_SEARCH, 16'h0061);
        send(OP_SEARCH, 16'h0062);
        send(OP_FINISH, 16'h0000);
        // load after search is dropped
        send(OP_LOAD, 16'h0078);
        send(OP_SEARCH, 16'h0079);
        send(OP_LOAD, 16'h007A);
        send(OP_FINISH, 16'h0000);

        stop_at = real_items() + RAND_ITEMS;
        while (real_items() < stop_at)
        begin
            idle_on = !(real_items() > stop_at - 600 && real_items() < stop_at - 400);
            shape = $urandom_range(99);
            wide  = ($urandom_range(3) == 0);
            base  = SYM_W'($urandom);
            if (shape < 70)
            begin
                rl = pick_len();
                sl = pick_len();
                repeat (rl) send(OP_LOAD, pick_sym(wide, base));
                repeat (sl)
                begin
                    if ($urandom_range(19) == 0) send(OP_UNUSED, SYM_W'($urandom));
                    send(OP_SEARCH, pick_sym(wide, base));
                end
                send(OP_FINISH, SYM_W'($urandom));
            end
            else if (shape < 85)
            begin
                repeat ($urandom_range(4)) send(OP_LOAD, pick_sym(wide, base));
                repeat ($urandom_range(1, 4)) send(OP_SEARCH, pick_sym(wide, base));
                repeat ($urandom_range(1, 3)) send(OP_LOAD, pick_sym(wide, base));
                repeat ($urandom_range(3)) send(OP_SEARCH, pick_sym(wide, base));
                send(OP_FINISH, SYM_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    send(OP_W'($urandom_range(3)), pick_sym(wide, base));
                send(OP_FINISH, SYM_W'($urandom));
            end
        end
        start <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (MAX_LEN + 8) @(posedge clk);
        @(negedge clk);

        $display("Requests: %0d loads, %0d searches, %0d finishes, %0d unused-op",
                 n_load, n_search, n_finish, n_unused);
        $display("Distances checked: %0d, mismatches: %0d", checked, fails);
        if (fails == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
design/ed_pkg.sv
design/ed_cell.sv
design/edit_distance_engine.sv
design/ed_checker.sv
sim/ed_checker.sv
sim/tb_top.sv
